// ----- src/rtpst_pkg.sv -----
// ----------------------------------------------------------------------------
// rtpst_pkg
// Shared widths, register indexes, reset values and payload types for the
// RTP sequence tracker.
// ----------------------------------------------------------------------------
package rtpst_pkg;

  localparam int SEQ_W   = 16;
  localparam int TS_W    = 32;
  localparam int CFG_W   = 15;
  localparam int CNT_W   = 32;
  localparam int GAP_W   = 15;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_DROPOUT  = 1'b0,
    CFG_MAX_MISORDER = 1'b1
  } cfg_index_t;

  localparam logic [CFG_W-1:0] MAX_DROPOUT_RESET  = 15'd3000;
  localparam logic [CFG_W-1:0] MAX_MISORDER_RESET = 15'd1500;

  // One incoming packet header.
  typedef struct packed {
    logic [SEQ_W-1:0] seq_number;
    logic [TS_W-1:0]  rtp_time;
    logic             report_gap;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic             accepted;
    logic             resynced;
    logic             gap_valid;
    logic [SEQ_W-1:0] gap_first;
    logic [SEQ_W-1:0] gap_end;
    logic [GAP_W-1:0] gap_length;
    logic [31:0]      extended_highest;
    logic [CNT_W-1:0] discard_total;
    logic [TS_W-1:0]  highest_time;
  } result_t;

  // Per-stream tracking state.
  typedef struct packed {
    logic             started;
    logic [SEQ_W-1:0] highest_seq;
    logic [SEQ_W-1:0] bad_candidate;
    logic             bad_candidate_valid;
    logic [SEQ_W-1:0] wrap_count;
    logic [TS_W-1:0]  highest_ts;
    logic [CNT_W-1:0] discard_count;
  } state_t;

  // Configuration values seen by the update logic.
  typedef struct packed {
    logic [CFG_W-1:0] max_dropout;
    logic [CFG_W-1:0] max_misorder;
  } cfg_t;

endpackage

// ----- src/rtpst_if.sv -----
// ----------------------------------------------------------------------------
// rtpst_if
// Valid/ready channels of the RTP sequence tracker: packet input, result
// output and configuration write.
// ----------------------------------------------------------------------------
interface rtpst_in_if;
  logic                          valid;
  logic                          ready;
  logic [rtpst_pkg::SEQ_W-1:0]   seq_number;
  logic [rtpst_pkg::TS_W-1:0]    rtp_time;
  logic                          report_gap;

  modport source (output valid, seq_number, rtp_time, report_gap, input ready);
  modport sink   (input valid, seq_number, rtp_time, report_gap, output ready);
endinterface

interface rtpst_out_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic                          resynced;
  logic                          gap_valid;
  logic [rtpst_pkg::SEQ_W-1:0]   gap_first;
  logic [rtpst_pkg::SEQ_W-1:0]   gap_end;
  logic [rtpst_pkg::GAP_W-1:0]   gap_length;
  logic [31:0]                   extended_highest;
  logic [rtpst_pkg::CNT_W-1:0]   discard_total;
  logic [rtpst_pkg::TS_W-1:0]    highest_time;

  modport source (output valid, accepted, resynced, gap_valid, gap_first, gap_end,
                  gap_length, extended_highest, discard_total, highest_time,
                  input ready);
  modport sink   (input valid, accepted, resynced, gap_valid, gap_first, gap_end,
                  gap_length, extended_highest, discard_total, highest_time,
                  output ready);
endinterface

interface rtpst_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rtpst_pkg::CFG_IDX_W-1:0]  index;
  logic [rtpst_pkg::CFG_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/rtp_sequence_tracker.sv -----
// ----------------------------------------------------------------------------
// rtp_sequence_tracker
// RTP sequence number validation for one stream: in-order, misorder, bad
// jump and resync classification, gap reporting and highest timestamp.
// ----------------------------------------------------------------------------
// Usage:
//   pkt_in carries one packet header per beat (sequence number, RTP
//   timestamp, gap-report request). res_out returns exactly one result beat
//   per packet, in order. cfg writes max_dropout (index 0) or max_misorder
//   (index 1); it is always ready and should only be used while no packet
//   is in flight.
//   Each packet is captured in an input register, updated against the
//   tracking state by combinational logic, and its result lands in an
//   output register, from which res_out is driven.
//   Throughput is one packet per cycle while res_out does not stall; the
//   state update is a few compares and 16/32-bit adds in combinational
//   logic, so consecutive packets see each other's state with no bubble.
//   When res_out stalls, the output register holds its beat, the input
//   register holds one more packet, and pkt_in.ready then drops.
//   Reset (rst, synchronous) empties both registers, clears the tracking
//   state and restores the default thresholds 3000 and 1500.
// ----------------------------------------------------------------------------
module rtp_sequence_tracker (
  input  logic             clk,
  input  logic             rst,
  rtpst_in_if.sink         pkt_in,
  rtpst_out_if.source      res_out,
  rtpst_cfg_if.sink        cfg
);

  logic                  in_vld;
  rtpst_pkg::item_t      in_item;
  logic                  out_vld;
  rtpst_pkg::result_t    out_res;
  rtpst_pkg::state_t     state;
  rtpst_pkg::state_t     state_next;
  rtpst_pkg::result_t    result_next;
  rtpst_pkg::cfg_t       cfg_regs;
  logic                  advance;
  logic                  take_in;

  // Handshake control: the input register advances when the output register
  // is empty or being drained this cycle.
  assign advance      = in_vld && (!out_vld || res_out.ready);
  assign take_in      = pkt_in.valid && pkt_in.ready;
  assign pkt_in.ready = !in_vld || advance;
  assign cfg.ready    = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.max_dropout  <= rtpst_pkg::MAX_DROPOUT_RESET;
      cfg_regs.max_misorder <= rtpst_pkg::MAX_MISORDER_RESET;
    end else if (cfg.valid) begin
      unique case (rtpst_pkg::cfg_index_t'(cfg.index))
        rtpst_pkg::CFG_MAX_DROPOUT:  cfg_regs.max_dropout  <= cfg.data;
        rtpst_pkg::CFG_MAX_MISORDER: cfg_regs.max_misorder <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (take_in) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_item.seq_number <= pkt_in.seq_number;
      in_item.rtp_time   <= pkt_in.rtp_time;
      in_item.report_gap <= pkt_in.report_gap;
    end
  end

  // Classification and state update.
  rtpst_update u_update (
    .state      (state),
    .item       (in_item),
    .cfg        (cfg_regs),
    .state_next (state_next),
    .result     (result_next)
  );

  // Tracking state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (res_out.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result_next;
    end
  end

  assign res_out.valid            = out_vld;
  assign res_out.accepted         = out_res.accepted;
  assign res_out.resynced         = out_res.resynced;
  assign res_out.gap_valid        = out_res.gap_valid;
  assign res_out.gap_first        = out_res.gap_first;
  assign res_out.gap_end          = out_res.gap_end;
  assign res_out.gap_length       = out_res.gap_length;
  assign res_out.extended_highest = out_res.extended_highest;
  assign res_out.discard_total    = out_res.discard_total;
  assign res_out.highest_time     = out_res.highest_time;

endmodule

// ----- src/rtpst_update.sv -----
// ----------------------------------------------------------------------------
// rtpst_update
// Classifies one packet against the tracking state and forms the next state
// and the result beat. Purely combinational.
// ----------------------------------------------------------------------------
module rtpst_update (
  input  rtpst_pkg::state_t  state,
  input  rtpst_pkg::item_t   item,
  input  rtpst_pkg::cfg_t    cfg,
  output rtpst_pkg::state_t  state_next,
  output rtpst_pkg::result_t result
);

  logic [rtpst_pkg::SEQ_W-1:0] seq;
  logic [rtpst_pkg::TS_W-1:0]  ts;
  logic [rtpst_pkg::SEQ_W-1:0] cur_highest;
  logic [rtpst_pkg::TS_W-1:0]  cur_ts;
  logic                        cur_cand_valid;
  logic [rtpst_pkg::SEQ_W-1:0] udelta;
  logic [rtpst_pkg::SEQ_W-1:0] udelta_m1;
  logic [rtpst_pkg::SEQ_W:0]   misorder_limit;
  logic                        in_order;
  logic                        bad_jump;
  logic                        resync;
  logic                        discard;
  logic [rtpst_pkg::TS_W-1:0]  ts_diff;
  logic                        ts_newer;

  assign seq = item.seq_number;
  assign ts  = item.rtp_time;

  // On the first packet the highest sequence is primed one below this one.
  assign cur_highest    = state.started ? state.highest_seq : seq - 16'd1;
  assign cur_ts         = state.started ? state.highest_ts : ts;
  assign cur_cand_valid = state.started & state.bad_candidate_valid;

  // Classification by forward distance from the highest sequence.
  assign udelta         = seq - cur_highest;
  assign udelta_m1      = udelta - 16'd1;
  assign misorder_limit = 17'h10000 - {2'b00, cfg.max_misorder};
  assign in_order       = udelta < {1'b0, cfg.max_dropout};
  assign bad_jump       = !in_order && ({1'b0, udelta} <= misorder_limit);
  assign resync         = bad_jump && cur_cand_valid && (seq == state.bad_candidate);
  assign discard        = bad_jump && !resync;

  // Serial comparison of the timestamp against the highest one. On the first
  // packet cur_ts already equals ts, and a resync takes ts outright, so in
  // both cases the comparison changes nothing further.
  assign ts_diff  = ts - cur_ts;
  assign ts_newer = ((ts_diff != '0) && !ts_diff[31]) ||
                    ((ts_diff == 32'h8000_0000) && (ts < cur_ts));

  // Next state.
  always_comb begin
    state_next                     = state;
    state_next.started             = 1'b1;
    state_next.highest_seq         = cur_highest;
    state_next.highest_ts          = cur_ts;
    state_next.bad_candidate_valid = cur_cand_valid;
    if (in_order) begin
      state_next.highest_seq = seq;
      if (seq < cur_highest) begin
        state_next.wrap_count = state.wrap_count + 16'd1;
      end
    end else if (resync) begin
      state_next.highest_seq         = seq;
      state_next.highest_ts          = ts;
      state_next.bad_candidate_valid = 1'b0;
    end else if (discard) begin
      state_next.bad_candidate       = seq + 16'd1;
      state_next.bad_candidate_valid = 1'b1;
      if (state.discard_count != '1) begin
        state_next.discard_count = state.discard_count + 32'd1;
      end
    end
    if (!discard && ts_newer) begin
      state_next.highest_ts = ts;
    end
  end

  // Result beat.
  always_comb begin
    result.accepted         = !discard;
    result.resynced         = resync;
    result.gap_valid        = 1'b0;
    result.gap_first        = '0;
    result.gap_end          = '0;
    result.gap_length       = '0;
    if (in_order && item.report_gap && (udelta > 16'd1)) begin
      result.gap_valid  = 1'b1;
      result.gap_first  = cur_highest + 16'd1;
      result.gap_end    = seq;
      result.gap_length = udelta_m1[rtpst_pkg::GAP_W-1:0];
    end
    result.extended_highest = {state_next.wrap_count, state_next.highest_seq};
    result.discard_total    = state_next.discard_count;
    result.highest_time     = state_next.highest_ts;
  end

endmodule
